>>> rtl/core/qle_pkg.sv
`timescale 1ns / 1ps

package qle_pkg;

    // field widths
    localparam int REQ_W     = 1;
    localparam int PAT_W     = 3;
    localparam int ACT_W     = 2;
    localparam int VAL_W     = 16;
    localparam int RATE_W    = 9;
    localparam int REWARD_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [PAT_W-1:0]     t_pat;
    typedef logic [ACT_W-1:0]     t_act;
    typedef logic [VAL_W-1:0]     t_val;
    typedef logic [RATE_W-1:0]    t_rate;

    // configuration register indexes
    localparam t_cfg_idx CFG_LEARN_RATE = 2'd0;
    localparam t_cfg_idx CFG_DISCOUNT   = 2'd1;
    localparam t_cfg_idx CFG_REWARD     = 2'd2;

    // reset values (alpha = gamma = 0.8, reward 5)
    localparam t_rate                RST_LEARN_RATE = 9'd205;
    localparam t_rate                RST_DISCOUNT   = 9'd205;
    localparam logic [REWARD_W-1:0]  RST_REWARD     = 8'd5;
    localparam t_rate                RATE_ONE       = 9'd256;

    // request kinds
    localparam logic REQ_TRAIN  = 1'b0;
    localparam logic REQ_CHOOSE = 1'b1;

    // action codes
    localparam t_act ACT_FORWARD = 2'd0;
    localparam t_act ACT_RIGHT   = 2'd1;
    localparam t_act ACT_LEFT    = 2'd2;
    localparam t_act ACT_STOP    = 2'd3;

    // sensor patterns (left, center, right)
    localparam t_pat PAT_CENTER      = 3'b010;
    localparam t_pat PAT_RIGHT       = 3'b001;
    localparam t_pat PAT_RIGHT_CTR   = 3'b011;
    localparam t_pat PAT_LEFT        = 3'b100;
    localparam t_pat PAT_LEFT_CTR    = 3'b110;
    localparam t_pat PAT_ALL         = 3'b111;

    // fixed reward rule on the raw sensor bits
    function automatic logic f_suits(input t_pat pat, input t_act act);
        logic ok;
        case (act)
            ACT_FORWARD: ok = (pat == PAT_CENTER);
            ACT_RIGHT:   ok = (pat == PAT_RIGHT) || (pat == PAT_RIGHT_CTR);
            ACT_LEFT:    ok = (pat == PAT_LEFT) || (pat == PAT_LEFT_CTR);
            ACT_STOP:    ok = (pat == PAT_ALL);
            default:     ok = 1'b0;
        endcase
        return ok;
    endfunction

    // clamp a rate to one
    function automatic t_rate f_clip(input t_rate r);
        return (r > RATE_ONE) ? RATE_ONE : r;
    endfunction

endpackage

>>> rtl/core/tabular_q_learning_engine_top.sv
`timescale 1ns / 1ps

// One request at a time; from the accepting edge, choose runs S_SCAN over the row
// (one table port, one row entry read per cycle); train, rewarded: S_QRD, S_QCHK,
// S_SCAN, S_MUL1, S_MUL2, S_WRITE; train, not rewarded: S_QRD, S_QCHK; an action
// out of range is answered straight from idle. The result strobe lasts one cycle
// and the receiver cannot stall it. Synchronous active-low reset, then a clear of
// every table entry with busy high; configuration writes are taken at any time.
module tabular_q_learning_engine_top #(
    parameter int NUM_STATES  = 8,
    parameter int NUM_ACTIONS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [qle_pkg::REQ_W-1:0] i_req_type,
    input  logic [qle_pkg::PAT_W-1:0] i_line_pattern,
    input  logic [qle_pkg::ACT_W-1:0] i_action,
    input  logic [qle_pkg::PAT_W-1:0] i_next_pattern,
    output logic                      o_done,
    output logic [qle_pkg::ACT_W-1:0] o_best_action,
    output logic                      o_rewarded,
    output logic [qle_pkg::VAL_W-1:0] o_value_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [qle_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [qle_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    import qle_pkg::*;

    localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
    localparam int ADW   = $clog2(DEPTH);
    localparam int RW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int AW    = $clog2(NUM_ACTIONS);
    localparam int CW    = $clog2(NUM_ACTIONS + 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_QRD   = 3'd2;
    localparam logic [2:0] S_QCHK  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_MUL1  = 3'd5;
    localparam logic [2:0] S_MUL2  = 3'd6;
    localparam logic [2:0] S_WRITE = 3'd7;

    // pattern mod NUM_STATES, pattern below 8 so a few subtract steps do
    function automatic logic [RW-1:0] f_row(input t_pat p);
        logic [8:0] v;
        v = {6'b0, p};
        for (int k = 0; k < 4; k++) begin
            if (v >= 9'(NUM_STATES)) begin
                v = v - 9'(NUM_STATES);
            end
        end
        return RW'(v);
    endfunction

    function automatic logic [ADW-1:0] f_base(input logic [RW-1:0] row);
        return ADW'(ADW'(row) * ADW'(NUM_ACTIONS));
    endfunction

    logic [2:0]          r_state, n_state;
    logic [ADW-1:0]      r_caddr, n_caddr;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_rv, n_rv;
    logic [AW-1:0]       r_ridx, n_ridx;
    logic                r_req, n_req;
    logic                r_suit, n_suit;
    logic [ADW-1:0]      r_qaddr, n_qaddr;
    logic [ADW-1:0]      r_base, n_base;
    t_val                r_q, n_q;
    t_val                r_best, n_best;
    logic [AW-1:0]       r_bidx, n_bidx;
    logic [24:0]         r_gq, n_gq;
    logic [24:0]         r_p1, n_p1;
    logic [26:0]         r_p2, n_p2;
    logic                r_done, n_done;
    t_act                r_bact, n_bact;
    logic                r_rewd, n_rewd;
    t_val                r_val, n_val;
    t_rate               r_lr;
    t_rate               r_disc;
    logic [REWARD_W-1:0] r_rew;

    logic                ram_we;
    logic [ADW-1:0]      ram_addr;
    t_val                ram_wdata;
    t_val                ram_rdata;

    logic                accept;
    logic [17:0]         target;
    logic [27:0]         sum;
    t_val                new_val;
    t_rate               alpha;

    qle_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // update datapath
    assign alpha   = f_clip(r_lr);
    assign target  = 18'({r_rew, 8'h00}) + 18'(r_gq[24:8]);
    assign sum     = 28'(r_p1) + 28'(r_p2);
    assign new_val = (|sum[27:24]) ? {VAL_W{1'b1}} : sum[23:8];

    // table port
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = new_val;
        ram_addr  = r_qaddr;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                ram_addr  = r_caddr;
            end
            S_SCAN: begin
                ram_addr = r_base + ADW'(r_cnt);
            end
            S_WRITE: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_addr = r_qaddr;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_caddr = r_caddr;
        n_cnt   = r_cnt;
        n_rv    = 1'b0;
        n_ridx  = r_cnt[AW-1:0];
        n_req   = r_req;
        n_suit  = r_suit;
        n_qaddr = r_qaddr;
        n_base  = r_base;
        n_q     = r_q;
        n_gq    = r_gq;
        n_p1    = r_p1;
        n_p2    = r_p2;
        n_done  = 1'b0;
        n_bact  = r_bact;
        n_rewd  = r_rewd;
        n_val   = r_val;

        // running first-highest over the row being read
        n_best = r_best;
        n_bidx = r_bidx;
        if (r_rv && ((r_ridx == '0) || (ram_rdata > r_best))) begin
            n_best = ram_rdata;
            n_bidx = r_ridx;
        end

        case (r_state)
            S_CLEAR: begin
                n_caddr = r_caddr + ADW'(1);
                if (r_caddr == ADW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_req  = i_req_type;
                    n_suit = f_suits(i_line_pattern, i_action);
                    n_cnt  = '0;
                    if (i_req_type == REQ_CHOOSE) begin
                        n_base  = f_base(f_row(i_line_pattern));
                        n_state = S_SCAN;
                    end else if (int'(i_action) >= NUM_ACTIONS) begin
                        n_done = 1'b1;
                        n_bact = '0;
                        n_rewd = 1'b0;
                        n_val  = '0;
                    end else begin
                        n_qaddr = f_base(f_row(i_line_pattern)) + ADW'(i_action);
                        n_base  = f_base(f_row(i_next_pattern));
                        n_state = S_QRD;
                    end
                end
            end
            S_QRD: begin
                n_state = S_QCHK;
            end
            S_QCHK: begin
                n_q = ram_rdata;
                if (!r_suit) begin
                    n_done  = 1'b1;
                    n_bact  = '0;
                    n_rewd  = 1'b0;
                    n_val   = ram_rdata;
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt < CW'(NUM_ACTIONS)) begin
                    n_rv  = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end else if (r_rv) begin
                    // last entry of the row arrives now
                    if (r_req == REQ_CHOOSE) begin
                        n_done  = 1'b1;
                        n_bact  = ACT_W'(n_bidx);
                        n_rewd  = 1'b0;
                        n_val   = n_best;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                n_gq    = 25'(f_clip(r_disc)) * 25'(r_best);
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_p1    = 25'(RATE_ONE - alpha) * 25'(r_q);
                n_p2    = 27'(alpha) * 27'(target);
                n_state = S_WRITE;
            end
            S_WRITE: begin
                n_done  = 1'b1;
                n_bact  = '0;
                n_rewd  = 1'b1;
                n_val   = new_val;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_caddr <= '0;
            r_cnt   <= '0;
            r_rv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_caddr <= n_caddr;
            r_cnt   <= n_cnt;
            r_rv    <= n_rv;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ridx  <= n_ridx;
        r_req   <= n_req;
        r_suit  <= n_suit;
        r_qaddr <= n_qaddr;
        r_base  <= n_base;
        r_q     <= n_q;
        r_best  <= n_best;
        r_bidx  <= n_bidx;
        r_gq    <= n_gq;
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_bact  <= n_bact;
        r_rewd  <= n_rewd;
        r_val   <= n_val;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr   <= RST_LEARN_RATE;
            r_disc <= RST_DISCOUNT;
            r_rew  <= RST_REWARD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LEARN_RATE: r_lr   <= i_cfg_data;
                CFG_DISCOUNT:   r_disc <= i_cfg_data;
                CFG_REWARD:     r_rew  <= i_cfg_data[REWARD_W-1:0];
                default:        r_lr   <= r_lr;
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_best_action = r_bact;
    assign o_rewarded    = r_rewd;
    assign o_value_out   = r_val;

    // reset always starts the clear pass
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("block not busy after reset");

    // an accepted transaction either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_done))
        else $error("accepted transaction dropped");

    // a rewarded result only comes out of the write-back step
    a_rewarded_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rewarded) |-> ($past(r_state) == S_WRITE))
        else $error("rewarded result without table write");

    // the row scan never issues past the end of the row
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= CW'(NUM_ACTIONS)))
        else $error("row scan overran");

endmodule

>>> rtl/core/qle_ram.sv
`timescale 1ns / 1ps

module qle_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
